// ===== rtl/slmb_pkg.sv =====
package slmb_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CMP_BITS-1:0] cmp_t;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_CONNECT = 3'd1;
	localparam logic [2:0] CMD_WARNING = 3'd2;
	localparam logic [2:0] CMD_ALERT = 3'd3;
	localparam logic [2:0] CMD_CONFIRM = 3'd4;
	localparam logic [2:0] CMD_BASE = 3'd5;
	localparam logic [2:0] CMD_STROBE = 3'd6;

	localparam logic [1:0] MODE_BASE = 2'd0;
	localparam logic [1:0] MODE_WARNING = 2'd1;
	localparam logic [1:0] MODE_ALERT = 2'd2;

	localparam logic [1:0] COL_OFF = 2'd0;
	localparam logic [1:0] COL_RED = 2'd1;
	localparam logic [1:0] COL_GREEN = 2'd2;
	localparam logic [1:0] COL_YELLOW = 2'd3;

	localparam logic [1:0] REG_SLOW = 2'd0;
	localparam logic [1:0] REG_FAST = 2'd1;
	localparam logic [1:0] REG_CONFIRM = 2'd2;

	localparam logic [CFG_BITS-1:0] SLOW_RESET = 16'd1000;
	localparam logic [CFG_BITS-1:0] FAST_RESET = 16'd200;
	localparam logic [CFG_BITS-1:0] CONFIRM_RESET = 16'd2000;

	typedef struct packed {
		logic [2:0] cmd;
		logic arg;
	} cmd_req_t;

	typedef struct packed {
		logic led_red;
		logic green_lit;
		logic strobe_out;
		logic [1:0] shown_color;
	} led_req_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] slow_period_ms;
		logic [CFG_BITS-1:0] fast_period_ms;
		logic [CFG_BITS-1:0] confirm_ms;
	} cfg_t;

endpackage

// ===== rtl/slmb_cfg.sv =====
module slmb_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [slmb_pkg::CFG_BITS-1:0] cfg_data,
	output slmb_pkg::cfg_t cfg
);

	slmb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_period_ms <= slmb_pkg::SLOW_RESET;
			cfg_q.fast_period_ms <= slmb_pkg::FAST_RESET;
			cfg_q.confirm_ms <= slmb_pkg::CONFIRM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				slmb_pkg::REG_SLOW: cfg_q.slow_period_ms <= cfg_data;
				slmb_pkg::REG_FAST: cfg_q.fast_period_ms <= cfg_data;
				slmb_pkg::REG_CONFIRM: cfg_q.confirm_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/slmb_core.sv =====
module slmb_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input slmb_pkg::cmd_req_t item,
	input slmb_pkg::cfg_t cfg,
	output slmb_pkg::led_req_t result
);

	logic [1:0] mode_q, mode_n;
	logic [1:0] color_q, color_n;
	slmb_pkg::timer_t blink_q, blink_n;
	slmb_pkg::timer_t celap_q, celap_n;
	logic cact_q, cact_n;
	logic csucc_q, csucc_n;
	logic conn_q, conn_n;
	logic strobe_q, strobe_n;
	logic mode_run;

	always_comb begin
		mode_n = mode_q;
		color_n = color_q;
		blink_n = blink_q;
		celap_n = celap_q;
		cact_n = cact_q;
		csucc_n = csucc_q;
		conn_n = conn_q;
		strobe_n = strobe_q;
		mode_run = 1'b1;

		case (item.cmd)
			slmb_pkg::CMD_CONNECT: conn_n = item.arg;
			slmb_pkg::CMD_WARNING: begin
				mode_n = slmb_pkg::MODE_WARNING;
				blink_n = '0;
			end
			slmb_pkg::CMD_ALERT: begin
				mode_n = slmb_pkg::MODE_ALERT;
				blink_n = '0;
			end
			slmb_pkg::CMD_CONFIRM: begin
				cact_n = 1'b1;
				celap_n = '0;
				csucc_n = item.arg;
			end
			slmb_pkg::CMD_BASE: begin
				mode_n = slmb_pkg::MODE_BASE;
				strobe_n = 1'b0;
			end
			slmb_pkg::CMD_STROBE: strobe_n = item.arg;
			default: ;
		endcase

		if (cact_n) begin
			if (slmb_pkg::cmp_t'(celap_n) >= slmb_pkg::cmp_t'(cfg.confirm_ms)) begin
				cact_n = 1'b0;
			end else begin
				color_n = csucc_n ? slmb_pkg::COL_GREEN : slmb_pkg::COL_RED;
				mode_run = 1'b0;
			end
		end

		if (mode_run) begin
			case (mode_n)
				slmb_pkg::MODE_BASE: begin
					color_n = conn_n ? slmb_pkg::COL_GREEN : slmb_pkg::COL_RED;
				end
				slmb_pkg::MODE_WARNING: begin
					if (slmb_pkg::cmp_t'(blink_n) >= slmb_pkg::cmp_t'(cfg.slow_period_ms)) begin
						blink_n = '0;
						color_n = (color_n == slmb_pkg::COL_YELLOW) ?
							slmb_pkg::COL_OFF : slmb_pkg::COL_YELLOW;
					end
				end
				slmb_pkg::MODE_ALERT: begin
					if (slmb_pkg::cmp_t'(blink_n) >= slmb_pkg::cmp_t'(cfg.fast_period_ms)) begin
						blink_n = '0;
						color_n = (color_n == slmb_pkg::COL_RED) ?
							slmb_pkg::COL_OFF : slmb_pkg::COL_RED;
					end
				end
				default: ;
			endcase
		end

		result.led_red = (color_n == slmb_pkg::COL_RED) || (color_n == slmb_pkg::COL_YELLOW);
		result.green_lit = (color_n == slmb_pkg::COL_GREEN) ||
			(color_n == slmb_pkg::COL_YELLOW);
		result.strobe_out = strobe_n;
		result.shown_color = color_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slmb_pkg::MODE_BASE;
			color_q <= slmb_pkg::COL_OFF;
			blink_q <= '0;
			celap_q <= '0;
			cact_q <= 1'b0;
			csucc_q <= 1'b0;
			conn_q <= 1'b0;
			strobe_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			color_q <= color_n;
			blink_q <= (blink_n == '1) ? blink_n : blink_n + 1'b1;
			celap_q <= (celap_n == '1) ? celap_n : celap_n + 1'b1;
			cact_q <= cact_n;
			csucc_q <= csucc_n;
			conn_q <= conn_n;
			strobe_q <= strobe_n;
		end
	end

endmodule

// ===== rtl/status_led_mode_blinker.sv =====
// Data path: an accepted request is held in the input register, and its result is captured
// in the output register once that register is free or the output side does not stall.
// Throughput: one request per cycle while the output side does not stall; the tick update
// is a single pass of compare logic between the input register and the output register.
// Reset: arst_n clears all mode, color, timer and flag state, empties both registers
// and loads the period and duration registers with their default values.
module status_led_mode_blinker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input slmb_pkg::cmd_req_t cmd_req,
	output logic led_valid,
	input logic led_stall,
	output slmb_pkg::led_req_t led_req,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [slmb_pkg::CFG_BITS-1:0] cfg_data
);

	slmb_pkg::cfg_t cfg;
	slmb_pkg::cmd_req_t req_s1;
	slmb_pkg::led_req_t result;
	slmb_pkg::led_req_t led_q;
	logic valid_s1;
	logic led_valid_q;
	logic advance;

	assign advance = valid_s1 && (!led_valid_q || !led_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign led_valid = led_valid_q;
	assign led_req = led_q;

	slmb_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	slmb_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(req_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			led_valid_q <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				led_valid_q <= 1'b1;
			end else if (!led_stall) begin
				led_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			req_s1 <= cmd_req;
		end
		if (advance) begin
			led_q <= result;
		end
	end

endmodule
